// ===== design/btas_pkg.sv =====
// ----------------------------------------------------------------------------
// btas_pkg
// Shared types, constants and helper functions of the block transfer
// address sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package btas_pkg;

   localparam int NUM_REGS    = 15;
   localparam int MASK_BITS   = 15;
   localparam int ADDR_BITS   = 32;
   localparam int INDEX_BITS  = 4;
   localparam int COUNT_BITS  = 4;
   localparam int WORD_BYTES  = 4;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = 1;
   localparam int QCNT_BITS   = 2;

   localparam int REQ_DATA_BITS = 56;
   localparam int RSP_DATA_BITS = 40;

   // one instruction as handed from front to back
   typedef struct packed {
      logic [MASK_BITS-1:0] mask;
      logic [ADDR_BITS-1:0] start_address;
      logic                 is_load;
   } desc_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // mask bits of registers that exist
   function automatic logic [MASK_BITS-1:0] reg_keep_mask();
      logic [MASK_BITS-1:0] keep;
      keep = '0;
      for (int i = 0; i < MASK_BITS; i++) begin
         keep[i] = (i < NUM_REGS);
      end
      return keep;
   endfunction

   function automatic logic [COUNT_BITS-1:0] count_ones(input logic [MASK_BITS-1:0] m);
      logic [COUNT_BITS-1:0] n;
      n = '0;
      for (int i = 0; i < MASK_BITS; i++) begin
         n = n + {{(COUNT_BITS-1){1'b0}}, m[i]};
      end
      return n;
   endfunction

   // index of the lowest set bit, zero for an empty mask
   function automatic logic [INDEX_BITS-1:0] lowest_index(input logic [MASK_BITS-1:0] m);
      logic [INDEX_BITS-1:0] idx;
      idx = '0;
      for (int i = MASK_BITS - 1; i >= 0; i--) begin
         if (m[i]) begin
            idx = INDEX_BITS'(i);
         end
      end
      return idx;
   endfunction

endpackage

`default_nettype wire

// ===== design/btas_front.sv =====
// ----------------------------------------------------------------------------
// btas_front
// Accepts instructions, drops empty masks and works out the address of the
// lowest register before handing the instruction to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module btas_front
   import btas_pkg::*;
(
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   input  wire logic [REQ_DATA_BITS-1:0] req_tdata,
   input  wire queue_status_type         q_status,
   output logic                          q_push,
   output desc_type                      q_desc
);

   localparam logic [MASK_BITS-1:0] KEEP = reg_keep_mask();

   logic [ADDR_BITS-1:0]  base_address;
   logic [MASK_BITS-1:0]  mask;
   logic                  before_step;
   logic                  upward;
   logic                  load_dir;
   logic [COUNT_BITS-1:0] n;
   logic [COUNT_BITS+1:0] span;
   logic [COUNT_BITS+1:0] down_offset;
   logic [ADDR_BITS-1:0]  start_address;

   assign base_address = req_tdata[31:0];
   assign mask         = req_tdata[46:32] & KEEP;
   assign before_step  = req_tdata[47];
   assign upward       = req_tdata[48];
   assign load_dir     = req_tdata[49];

   assign n    = count_ones(mask);
   assign span = {n, 2'b00};

   // decrement-after ends at base, so the lowest word sits one word above base-4n
   assign down_offset = before_step ? span
                                    : span - (COUNT_BITS+2)'(WORD_BYTES);

   always_comb begin
      if (upward) begin
         start_address = before_step ? base_address + ADDR_BITS'(WORD_BYTES)
                                     : base_address;
      end else begin
         start_address = base_address - {{(ADDR_BITS-COUNT_BITS-2){1'b0}}, down_offset};
      end
   end

   assign req_tready            = !q_status.full;
   assign q_push                = req_tvalid && req_tready && (mask != '0);
   assign q_desc.mask           = mask;
   assign q_desc.start_address  = start_address;
   assign q_desc.is_load        = load_dir;

endmodule

`default_nettype wire

// ===== design/btas_queue.sv =====
// ----------------------------------------------------------------------------
// btas_queue
// Short instruction queue between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module btas_queue
   import btas_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire desc_type   push_desc,
   input  wire logic       pop,
   output desc_type        head_desc,
   output queue_status_type status
);

   desc_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wptr_ff, wptr_in;
   logic [QPTR_BITS-1:0] rptr_ff, rptr_in;
   logic [QCNT_BITS-1:0] count_ff, count_in;
   logic                 do_push;
   logic                 do_pop;

   assign status.full  = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head_desc    = entry_ff[rptr_ff];

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wptr_in = (wptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (do_pop) begin
         rptr_in = (rptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wptr_ff] <= push_desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/btas_back.sv =====
// ----------------------------------------------------------------------------
// btas_back
// Walks the held mask one set bit per cycle while rsp_tready is high and issues one transfer for each.
// ----------------------------------------------------------------------------
`default_nettype none

module btas_back
   import btas_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire queue_status_type         q_status,
   input  wire desc_type                 q_head,
   output logic                          q_pop,
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0]      rsp_tdata,
   output logic                          rsp_tlast
);

   logic                 busy_ff, busy_in;
   logic [MASK_BITS-1:0] mask_ff, mask_in;
   logic [ADDR_BITS-1:0] addr_ff, addr_in;
   logic                 load_ff, load_in;
   logic [MASK_BITS-1:0] rest_mask;
   logic                 fire;
   logic                 final_one;

   assign rest_mask = mask_ff & (mask_ff - 1'b1);
   assign final_one = (rest_mask == '0);
   assign fire      = busy_ff && rsp_tready;
   // next instruction loads when idle or as the final transfer leaves
   assign q_pop     = !q_status.empty && (!busy_ff || (fire && final_one));

   always_comb begin
      busy_in = busy_ff;
      mask_in = mask_ff;
      addr_in = addr_ff;
      load_in = load_ff;
      if (q_pop) begin
         busy_in = 1'b1;
         mask_in = q_head.mask;
         addr_in = q_head.start_address;
         load_in = q_head.is_load;
      end else if (fire) begin
         busy_in = !final_one;
         mask_in = rest_mask;
         addr_in = addr_ff + ADDR_BITS'(WORD_BYTES);
      end
   end

   always_ff @(posedge clock) begin
      mask_ff <= mask_in;
      addr_ff <= addr_in;
      load_ff <= load_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   assign rsp_tvalid = busy_ff;
   assign rsp_tlast  = final_one;
   assign rsp_tdata  = {{(RSP_DATA_BITS-INDEX_BITS-ADDR_BITS-1){1'b0}},
                        load_ff, addr_ff, lowest_index(mask_ff)};

endmodule

`default_nettype wire

// ===== design/block_transfer_address_sequencer.sv =====
// ----------------------------------------------------------------------------
// block_transfer_address_sequencer
// Turns one block-transfer instruction into one word transfer per register
// in its mask, lowest register at the lowest address.
// ----------------------------------------------------------------------------
//  channel  direction  transaction
//  req_*    in         one instruction: base, mask, before/up/load bits
//  rsp_*    out        one transfer: register, word address, direction, last
//
//  an instruction with n set mask bits gives n transfers, one per cycle while rsp_tready is high;
//  the back part's walk over the held mask (lowest-bit encode) sets this rate
//  an empty mask is accepted but gives no transfer
//  a two-deep queue lets new instructions enter while transfers are stalled
//  reset clears the queue and the back part, no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module block_transfer_address_sequencer
   import btas_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   // base_address[31:0], register_mask[46:32], before_step[47], upward[48],
   // load_dir[49], zero[55:50]
   input  wire logic [REQ_DATA_BITS-1:0] req_tdata,
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   // reg_index[3:0], word_address[35:4], is_load[36], zero[39:37]
   output logic [RSP_DATA_BITS-1:0]      rsp_tdata,
   output logic                          rsp_tlast
);

   queue_status_type q_status;
   logic             q_push;
   logic             q_pop;
   desc_type         push_desc;
   desc_type         head_desc;

   btas_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_status   (q_status),
      .q_push     (q_push),
      .q_desc     (push_desc)
   );

   btas_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_desc (push_desc),
      .pop       (q_pop),
      .head_desc (head_desc),
      .status    (q_status)
   );

   btas_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_status   (q_status),
      .q_head     (head_desc),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef SYNTHESIS
   // a transfer that is not the last one is followed by more of the same instruction
   a_more_follow: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid)
      else $error("transfer sequence broke off before last");

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[INDEX_BITS-1:0] < INDEX_BITS'(NUM_REGS)))
      else $error("register index out of range");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_status.full |-> !q_push)
      else $error("push into full queue");

   // consecutive transfers of one instruction are one word apart
   a_addr_step: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=>
         (rsp_tdata[35:4] == $past(rsp_tdata[35:4]) + ADDR_BITS'(WORD_BYTES)))
      else $error("address step is not one word");
`endif

endmodule

`default_nettype wire
